// ===== rtl/antialiased_shape_color_fill_core_defines.svh =====
// assertion macros for the antialiased shape color fill core
// expects i_clk and i_rst_n in the scope of use
`ifndef ANTIALIASED_SHAPE_COLOR_FILL_CORE_DEFINES_SVH
`define ANTIALIASED_SHAPE_COLOR_FILL_CORE_DEFINES_SVH

// same-cycle implication
`define ACS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("acs assertion failed");

// next-cycle implication
`define ACS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("acs assertion failed");

`endif

// ===== rtl/acs_pkg.sv =====
// shared types and constants of the antialiased shape color fill core
// no dependencies
package acs_pkg;

    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_ONE  = 2'd1,
        CLS_LINE = 2'd2,
        CLS_DISC = 2'd3
    } t_cls;

    typedef enum logic [2:0] {
        CFG_SHAPE_MODE  = 3'd0,
        CFG_ANCHOR_COL  = 3'd1,
        CFG_ANCHOR_ROW  = 3'd2,
        CFG_DIRECTION   = 3'd3,
        CFG_DISC_RADIUS = 3'd4,
        CFG_FILL_COLOR  = 3'd5,
        CFG_SCALE_X     = 3'd6,
        CFG_SCALE_Y     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               shape_mode;
        logic signed [15:0] anchor_col;
        logic signed [15:0] anchor_row;
        logic [31:0]        direction;
        logic [11:0]        disc_radius;
        logic [23:0]        fill_color;
        logic [11:0]        scale_x;
        logic [11:0]        scale_y;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pix;

    localparam int VAL_W    = 40;
    localparam int SQ_IN_W  = 56;
    localparam int SQ_OUT_W = 28;
    localparam int LPROD_W  = 39;

    typedef struct packed {
        t_cls              cls;
        logic [VAL_W-1:0]  val;
        t_pix              pix;
    } t_qent;

    typedef struct packed {
        t_cls               cls;
        logic [LPROD_W-1:0] lprod;
        t_pix               pix;
    } t_side;

    typedef struct packed {
        logic q_empty;
        logic of_full;
    } t_bk_stat;

    localparam logic [22:0] EDGE_Q22     = 23'd2965821;
    localparam logic [22:0] EDGE2_Q22    = 23'd5931642;
    localparam logic [15:0] EDGE_Q16     = 16'd46341;
    localparam logic [7:0]  EDGE_Q8      = 8'd181;
    localparam logic [15:0] INV_SQRT2    = 16'd46341;
    localparam logic [16:0] COV_PASS_MAX = 17'd6;
    localparam logic [16:0] COV_FILL_MIN = 17'd65530;
    localparam logic [16:0] COV_ONE      = 17'd65536;

endpackage

// ===== rtl/antialiased_shape_color_fill_core.sv =====
// antialiased half-plane or disc fill with one color, one pixel per cycle
// an accepted push passes the front part, the queue and the back part with its
//   28-stage square root pipeline before its result reaches the result queue head
// throughput: one pixel per cycle while results are popped
// reset: synchronous active low, clears queues and pipelines, loads register defaults
module antialiased_shape_color_fill_core #(
    parameter int COORD_BITS = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [COORD_BITS-1:0] i_pix_x,
    input  logic [COORD_BITS-1:0] i_pix_y,
    input  logic [7:0]            i_in_red,
    input  logic [7:0]            i_in_green,
    input  logic [7:0]            i_in_blue,
    input  logic [7:0]            i_in_alpha,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic [7:0]            o_out_alpha,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    `include "antialiased_shape_color_fill_core_defines.svh"

    localparam int QE_W = $bits(acs_pkg::t_qent);
    localparam int PX_W = $bits(acs_pkg::t_pix);

    acs_pkg::t_cfg     r_cfg;
    acs_pkg::t_pix     in_pix, res, head;
    acs_pkg::t_qent    q_went, q_rent;
    acs_pkg::t_bk_stat stat;
    logic [QE_W-1:0]   q_rdata;
    logic [PX_W-1:0]   of_rdata;
    logic              q_push, q_pop, q_full, q_empty;
    logic              of_push, of_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shape_mode  <= 1'b0;
            r_cfg.anchor_col  <= 16'sd50;
            r_cfg.anchor_row  <= 16'sd50;
            r_cfg.direction   <= 32'h4000_0000;
            r_cfg.disc_radius <= 12'd100;
            r_cfg.fill_color  <= 24'hFF0000;
            r_cfg.scale_x     <= 12'd256;
            r_cfg.scale_y     <= 12'd256;
        end else if (i_cfg_valid) begin
            unique case (acs_pkg::t_cfg_idx'(i_cfg_index))
                acs_pkg::CFG_SHAPE_MODE:  r_cfg.shape_mode  <= i_cfg_data[0];
                acs_pkg::CFG_ANCHOR_COL:  r_cfg.anchor_col  <= $signed(i_cfg_data[15:0]);
                acs_pkg::CFG_ANCHOR_ROW:  r_cfg.anchor_row  <= $signed(i_cfg_data[15:0]);
                acs_pkg::CFG_DIRECTION:   r_cfg.direction   <= i_cfg_data;
                acs_pkg::CFG_DISC_RADIUS: r_cfg.disc_radius <= i_cfg_data[11:0];
                acs_pkg::CFG_FILL_COLOR:  r_cfg.fill_color  <= i_cfg_data[23:0];
                acs_pkg::CFG_SCALE_X:     r_cfg.scale_x     <= i_cfg_data[11:0];
                acs_pkg::CFG_SCALE_Y:     r_cfg.scale_y     <= i_cfg_data[11:0];
            endcase
        end
    end

    assign in_pix.red   = i_in_red;
    assign in_pix.green = i_in_green;
    assign in_pix.blue  = i_in_blue;
    assign in_pix.alpha = i_in_alpha;

    acs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .o_full   (full),
        .i_pix_x  (i_pix_x),
        .i_pix_y  (i_pix_y),
        .i_pix    (in_pix),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_ent  (q_went)
    );

    acs_fifo #(
        .WIDTH (QE_W),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_went),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign q_rent       = acs_pkg::t_qent'(q_rdata);
    assign stat.q_empty = q_empty;
    assign stat.of_full = of_full;

    acs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_stat  (stat),
        .i_q_ent (q_rent),
        .o_q_pop (q_pop),
        .o_push  (of_push),
        .o_res   (res)
    );

    acs_fifo #(
        .WIDTH (PX_W),
        .DEPTH (4)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (of_push),
        .i_wdata (res),
        .i_pop   (pop),
        .o_rdata (of_rdata),
        .o_full  (of_full),
        .o_empty (empty)
    );

    assign head        = acs_pkg::t_pix'(of_rdata);
    assign o_out_red   = head.red;
    assign o_out_green = head.green;
    assign o_out_blue  = head.blue;
    assign o_out_alpha = head.alpha;

    `ACS_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full)
    `ACS_ASSERT_IMP(a_outq_no_overflow, of_push, !of_full)
    `ACS_ASSERT_IMP(a_pop_only_nonempty, q_pop, !q_empty)
    `ACS_ASSERT_NXT(a_fill_write, i_cfg_valid && (i_cfg_index == acs_pkg::CFG_FILL_COLOR),
                    r_cfg.fill_color == $past(i_cfg_data[23:0]))
endmodule

// ===== rtl/acs_fifo.sv =====
// small register queue with combinational head
// no dependencies
module acs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end
endmodule

// ===== rtl/acs_front.sv =====
// front part: anchor offset, scaling, projection or squared distance, classification
// depends on acs_pkg
module acs_front #(
    parameter int COORD_BITS = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  acs_pkg::t_cfg         i_cfg,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [COORD_BITS-1:0] i_pix_x,
    input  logic [COORD_BITS-1:0] i_pix_y,
    input  acs_pkg::t_pix         i_pix,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output acs_pkg::t_qent        o_q_ent
);
    localparam int DXW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
    localparam int FXW = DXW + 13;
    localparam int PW  = FXW + 16;
    localparam int SW  = 2 * FXW;
    localparam int RW  = PW + 1;
    localparam int DW  = SW + 1;

    logic [3:0] r_vld;
    logic       adv;

    logic signed [DXW-1:0] r_dx, r_dy;
    logic signed [FXW-1:0] r_fx, r_fy;
    logic signed [PW-1:0]  r_pc, r_ps;
    logic signed [SW-1:0]  r_sx2, r_sy2;
    logic [41:0]           r_rp2, r_rm2;
    logic                  r_rnz;
    acs_pkg::t_pix         r_pix1, r_pix2, r_pix3;
    acs_pkg::t_qent        r_ent, n_ent;

    logic [20:0]           rp;
    logic [20:0]           rm;
    logic signed [RW-1:0]  t_line;
    logic [DW-1:0]         d2;

    assign adv      = !(r_vld[3] && i_q_full);
    assign o_full   = !adv;
    assign o_q_push = r_vld[3] && adv;
    assign o_q_ent  = r_ent;

    assign rp = 21'({i_cfg.disc_radius, 8'b0}) + 21'(acs_pkg::EDGE_Q8);
    assign rm = 21'({i_cfg.disc_radius, 8'b0}) - 21'(acs_pkg::EDGE_Q8);

    assign t_line = RW'(r_pc) + RW'(r_ps) + $signed(RW'(acs_pkg::EDGE_Q22));
    assign d2     = DW'($unsigned(r_sx2)) + DW'($unsigned(r_sy2));

    always_comb begin
        n_ent     = '0;
        n_ent.pix = r_pix3;
        if (!i_cfg.shape_mode) begin
            if (t_line <= 0) begin
                n_ent.cls = acs_pkg::CLS_ZERO;
            end else if (t_line >= $signed(RW'(acs_pkg::EDGE2_Q22))) begin
                n_ent.cls = acs_pkg::CLS_ONE;
            end else begin
                n_ent.cls = acs_pkg::CLS_LINE;
                n_ent.val = acs_pkg::VAL_W'(t_line[22:0]);
            end
        end else begin
            if (d2 >= DW'(r_rp2)) begin
                n_ent.cls = acs_pkg::CLS_ZERO;
            end else if (r_rnz && d2 <= DW'(r_rm2)) begin
                n_ent.cls = acs_pkg::CLS_ONE;
            end else begin
                n_ent.cls = acs_pkg::CLS_DISC;
                n_ent.val = d2[acs_pkg::VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[2:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx   <= $signed(DXW'(i_pix_x)) - DXW'(i_cfg.anchor_col);
            r_dy   <= $signed(DXW'(i_pix_y)) - DXW'(i_cfg.anchor_row);
            r_pix1 <= i_pix;
            r_fx   <= r_dx * $signed({1'b0, i_cfg.scale_x});
            r_fy   <= r_dy * $signed({1'b0, i_cfg.scale_y});
            r_pix2 <= r_pix1;
            r_pc   <= r_fx * $signed(i_cfg.direction[31:16]);
            r_ps   <= r_fy * $signed(i_cfg.direction[15:0]);
            r_sx2  <= r_fx * r_fx;
            r_sy2  <= r_fy * r_fy;
            r_rp2  <= 42'(rp) * 42'(rp);
            r_rm2  <= 42'(rm) * 42'(rm);
            r_rnz  <= |i_cfg.disc_radius;
            r_pix3 <= r_pix2;
            r_ent  <= n_ent;
        end
    end
endmodule

// ===== rtl/acs_sqrt.sv =====
// pipelined integer square root, one result bit per stage, with side data
// no dependencies
module acs_sqrt #(
    parameter int IN_W   = 56,
    parameter int SIDE_W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [IN_W-1:0]     i_val,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_vld,
    output logic [IN_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);
    localparam int OUT_W = IN_W / 2;
    localparam int REMW  = OUT_W + 2;

    logic              w_vld  [OUT_W+1];
    logic [REMW-1:0]   w_rem  [OUT_W+1];
    logic [OUT_W-1:0]  w_root [OUT_W+1];
    logic [SIDE_W-1:0] w_side [OUT_W+1];
    logic [IN_W-1:0]   w_val  [OUT_W];

    assign w_vld[0]  = i_vld;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;
    assign w_val[0]  = i_val;

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        logic [REMW-1:0]  cur, trial;
        logic             ge;
        logic             r_vld;
        logic [REMW-1:0]  r_rem;
        logic [OUT_W-1:0] r_root;
        logic [SIDE_W-1:0] r_side;

        assign cur   = {w_rem[k][REMW-3:0], w_val[k][IN_W-1 -: 2]};
        assign trial = {w_root[k], 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= ge ? cur - trial : cur;
                r_root <= {w_root[k][OUT_W-2:0], ge};
                r_side <= w_side[k];
            end
        end

        assign w_vld[k+1]  = r_vld;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_side[k+1] = r_side;

        if (k < OUT_W - 1) begin : g_val
            logic [IN_W-1:0] r_val;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_val <= {w_val[k][IN_W-3:0], 2'b00};
                end
            end
            assign w_val[k+1] = r_val;
        end
    end

    assign o_vld  = w_vld[OUT_W];
    assign o_root = w_root[OUT_W];
    assign o_side = w_side[OUT_W];
endmodule

// ===== rtl/acs_back.sv =====
// back part: band coverage through the square root pipeline, then color blend
// depends on acs_pkg and acs_sqrt
module acs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  acs_pkg::t_cfg     i_cfg,
    input  acs_pkg::t_bk_stat i_stat,
    input  acs_pkg::t_qent    i_q_ent,
    output logic              o_q_pop,
    output logic              o_push,
    output acs_pkg::t_pix     o_res
);
    localparam int RTW = acs_pkg::SQ_OUT_W;

    function automatic logic [7:0] blend(input logic [7:0] src, input logic [7:0] dst,
                                         input logic [16:0] cov);
        logic [25:0] acc;
        acc = 26'(src) * 26'(acs_pkg::COV_ONE - cov) + 26'(dst) * 26'(cov) + 26'd32768;
        if (cov <= acs_pkg::COV_PASS_MAX) begin
            return src;
        end else if (cov >= acs_pkg::COV_FILL_MIN) begin
            return dst;
        end
        return acc[23:16];
    endfunction

    logic adv, pop;
    logic [3:0] r_vc;

    logic                         r_v1;
    acs_pkg::t_side               r_side1;
    logic [acs_pkg::SQ_IN_W-1:0]  r_sq_in;

    logic                         s_vld;
    logic [RTW-1:0]               s_root;
    acs_pkg::t_side               s_side;

    acs_pkg::t_cls   r_cls1, r_cls2, r_cls3;
    acs_pkg::t_pix   r_pix1, r_pix2, r_pix3;
    logic [17:0]     r_lc1, r_lc2;
    logic signed [29:0] r_s;
    logic [44:0]     r_dprod;
    logic            r_sneg;
    logic [16:0]     r_cov, n_cov;
    acs_pkg::t_pix   r_res;
    logic [28:0]     dc;
    logic [38:0]     lsum;

    assign adv     = !(r_vc[3] && i_stat.of_full);
    assign pop     = adv && !i_stat.q_empty;
    assign o_q_pop = pop;
    assign o_push  = r_vc[3] && adv;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_vc <= '0;
        end else if (adv) begin
            r_v1 <= pop;
            r_vc <= {r_vc[2:0], s_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side1.cls   <= i_q_ent.cls;
            r_side1.lprod <= acs_pkg::LPROD_W'(i_q_ent.val[22:0])
                             * acs_pkg::LPROD_W'(acs_pkg::INV_SQRT2);
            r_side1.pix   <= i_q_ent.pix;
            r_sq_in       <= {i_q_ent.val, 16'b0};
        end
    end

    acs_sqrt #(
        .IN_W   (acs_pkg::SQ_IN_W),
        .SIDE_W ($bits(acs_pkg::t_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_v1),
        .i_val   (r_sq_in),
        .i_side  (r_side1),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    assign lsum = s_side.lprod + 39'd2097152;
    assign dc   = 29'((r_dprod + 45'd32768) >> 16);

    always_comb begin
        unique case (r_cls2)
            acs_pkg::CLS_ZERO: n_cov = '0;
            acs_pkg::CLS_ONE:  n_cov = acs_pkg::COV_ONE;
            acs_pkg::CLS_LINE: n_cov = (r_lc2 > 18'(acs_pkg::COV_ONE)) ? acs_pkg::COV_ONE
                                                                     : r_lc2[16:0];
            acs_pkg::CLS_DISC: n_cov = r_sneg ? '0
                                     : ((dc > 29'(acs_pkg::COV_ONE)) ? acs_pkg::COV_ONE
                                                                      : dc[16:0]);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cls1  <= s_side.cls;
            r_pix1  <= s_side.pix;
            r_lc1   <= lsum[38:21] >> 1;
            r_s     <= $signed({2'b00, i_cfg.disc_radius, 16'b0})
                       + $signed(30'(acs_pkg::EDGE_Q16)) - $signed(30'(s_root));
            r_cls2  <= r_cls1;
            r_pix2  <= r_pix1;
            r_lc2   <= r_lc1;
            r_dprod <= 45'(r_s[28:0]) * 45'(acs_pkg::INV_SQRT2);
            r_sneg  <= r_s[29] || (r_s == '0);
            r_cls3  <= r_cls2;
            r_pix3  <= r_pix2;
            r_cov   <= n_cov;
            r_res.red   <= blend(r_pix3.red,   i_cfg.fill_color[23:16], r_cov);
            r_res.green <= blend(r_pix3.green, i_cfg.fill_color[15:8],  r_cov);
            r_res.blue  <= blend(r_pix3.blue,  i_cfg.fill_color[7:0],   r_cov);
            r_res.alpha <= r_pix3.alpha;
        end
    end
endmodule
